/* sv/qte_pkg.sv */
// Shared widths, constants, CORDIC angle table and queue item type for the quaternion converter.
`default_nettype none
package qte_pkg;
	localparam int QUAT_W     = 16;
	localparam int PROD_W     = 2 * QUAT_W;
	localparam int SUM_W      = PROD_W + 3;
	localparam int FRAC_W     = 14;
	localparam int PROD_FRAC  = 28;
	localparam int QSHIFT     = PROD_FRAC - FRAC_W;
	localparam int TERM_W     = SUM_W - QSHIFT;
	localparam int SIN_W      = 16;
	localparam int MAG_W      = 15;
	localparam int ROOT_IN_W  = 2 * FRAC_W + 1;
	localparam int ROOT_STEPS = FRAC_W + 1;
	localparam int CORD_W     = TERM_W + 3;
	localparam int ANG_W      = 32;
	localparam int OUT_W      = 16;
	localparam int STEPS      = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(1) <<< PROD_FRAC;
	localparam logic [ROOT_IN_W-1:0] ONE_SQ = ROOT_IN_W'(1) << (2 * FRAC_W);
	localparam logic signed [OUT_W-1:0] HALF_PI = OUT_W'(16384);
	localparam logic [ANG_W-1:0] PI_ANG = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ROUND_HALF = 32'h0000_8000;

	localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [TERM_W-1:0] sinr;
		logic signed [TERM_W-1:0] cosr;
		logic signed [TERM_W-1:0] siny;
		logic signed [TERM_W-1:0] cosy;
		logic signed [SIN_W-1:0]  sinp;
		logic                     clamp;
		logic                     clamp_neg;
	} qte_item_t;
endpackage
`default_nettype wire

/* sv/quaternion_to_euler.sv */
// Top level: quaternion to ZYX Euler angle converter with stream ports.
//
// Converts one Q1.14 quaternion per beat into roll, pitch and yaw binary
// angles (32768 = pi). One beat is accepted every clock cycle when nothing
// stalls; an accepted input beat passes through two front stages for
// products and quantisation, one queue stage, one pop register, one square
// root setup stage plus 15 square root stages for the pitch cosine, one
// CORDIC setup stage plus 16 CORDIC stages, and the output register. A
// four-entry queue between front and back lets each side stall on its own.
// m_axis_tuser flags a pitch saturated to plus or minus half pi.
`default_nettype none
module quaternion_to_euler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // q_w, q_x, q_y, q_z
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
	output logic [0:0]       m_axis_tuser    // pitch_clamped
);
	import qte_pkg::*;

	logic push, pop, full, empty;
	qte_item_t item_f, item_b;
	logic signed [OUT_W-1:0] roll, pitch, yaw;
	logic clamp;

	qte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.q_w      ($signed(s_axis_tdata[15:0])),
		.q_x      ($signed(s_axis_tdata[31:16])),
		.q_y      ($signed(s_axis_tdata[47:32])),
		.q_z      ($signed(s_axis_tdata[63:48])),
		.full     (full),
		.push     (push),
		.item     (item_f)
	);

	qte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (item_f),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.item_out (item_b)
	);

	qte_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.item          (item_b),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.roll_angle    (roll),
		.pitch_angle   (pitch),
		.yaw_angle     (yaw),
		.pitch_clamped (clamp)
	);

	assign m_axis_tdata = {yaw, pitch, roll};
	assign m_axis_tuser = clamp;
endmodule
`default_nettype wire

/* sv/qte_front.sv */
// Front end: accept quaternions, form product sums, quantise and classify the pitch term.
`default_nettype none
module qte_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [qte_pkg::QUAT_W-1:0] q_w,
	input  wire logic signed [qte_pkg::QUAT_W-1:0] q_x,
	input  wire logic signed [qte_pkg::QUAT_W-1:0] q_y,
	input  wire logic signed [qte_pkg::QUAT_W-1:0] q_z,
	input  wire logic                             full,
	output logic                                  push,
	output qte_pkg::qte_item_t                     item
);
	import qte_pkg::*;

	logic ce;
	logic vld_s1, vld_s2;
	logic signed [PROD_W-1:0] wx_s1, yz_s1, wy_s1, zx_s1, wz_s1, xy_s1, xx_s1, yy_s1, zz_s1;
	logic signed [SUM_W-1:0] sinr_f, cosr_f, sinp_f, siny_f, cosy_f;
	qte_item_t item_s2, item_d;

	assign ce       = !(vld_s2 && full);
	assign in_ready = ce;
	assign push     = vld_s2 && !full;
	assign item     = item_s2;

	assign sinr_f = (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
	assign cosr_f = ONE_Q28 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
	assign sinp_f = (SUM_W'(wy_s1) - SUM_W'(zx_s1)) <<< 1;
	assign siny_f = (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
	assign cosy_f = ONE_Q28 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);

	always_comb begin
		item_d.sinr      = TERM_W'(sinr_f >>> QSHIFT);
		item_d.cosr      = TERM_W'(cosr_f >>> QSHIFT);
		item_d.siny      = TERM_W'(siny_f >>> QSHIFT);
		item_d.cosy      = TERM_W'(cosy_f >>> QSHIFT);
		item_d.sinp      = SIN_W'(sinp_f >>> QSHIFT);
		item_d.clamp     = (sinp_f >= ONE_Q28) || (sinp_f <= -ONE_Q28);
		item_d.clamp_neg = sinp_f[SUM_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			wx_s1   <= q_w * q_x;
			yz_s1   <= q_y * q_z;
			wy_s1   <= q_w * q_y;
			zx_s1   <= q_z * q_x;
			wz_s1   <= q_w * q_z;
			xy_s1   <= q_x * q_y;
			xx_s1   <= q_x * q_x;
			yy_s1   <= q_y * q_y;
			zz_s1   <= q_z * q_z;
			item_s2 <= item_d;
		end
	end
endmodule
`default_nettype wire

/* sv/qte_queue.sv */
// Short queue of classified items between the front and back ends.
`default_nettype none
module qte_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire qte_pkg::qte_item_t item_in,
	output logic                   full,
	input  wire logic              pop,
	output logic                   empty,
	output qte_pkg::qte_item_t     item_out
);
	import qte_pkg::*;

	qte_item_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign item_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
endmodule
`default_nettype wire

/* sv/qte_back.sv */
// Back end: pitch cosine by pipelined square root, three pipelined CORDIC arctangents, output register.
`default_nettype none
module qte_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          empty,
	input  wire qte_pkg::qte_item_t             item,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [qte_pkg::OUT_W-1:0]    roll_angle,
	output logic signed [qte_pkg::OUT_W-1:0]    pitch_angle,
	output logic signed [qte_pkg::OUT_W-1:0]    yaw_angle,
	output logic                               pitch_clamped
);
	import qte_pkg::*;

	typedef struct packed {
		logic signed [CORD_W-1:0] x;
		logic signed [CORD_W-1:0] y;
		logic [ANG_W-1:0]         z;
		logic                     zero;
	} qte_chan_t;

	logic ce;
	logic vld_s0;
	qte_item_t it_s0;
	logic [ROOT_STEPS:0] vld_r;
	qte_item_t itm_r [ROOT_STEPS+1];
	logic [ROOT_IN_W-1:0] rem_r [ROOT_STEPS+1];
	logic [ROOT_IN_W-1:0] res_r [ROOT_STEPS+1];
	logic [STEPS:0] vld_c, clamp_c, neg_c;
	qte_chan_t ch_c [STEPS+1][3];
	logic [MAG_W-1:0] mag;
	logic [2*MAG_W-1:0] sq;
	logic signed [CORD_W-1:0] px [3];
	logic signed [CORD_W-1:0] py [3];
	logic out_valid_q, clamp_q;
	logic signed [OUT_W-1:0] roll_q, pitch_q, yaw_q;
	logic [ANG_W-1:0] rnd [3];
	logic signed [OUT_W-1:0] ang [3];

	assign ce  = !out_valid_q || out_ready;
	assign pop = ce && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (ce) begin
			vld_s0 <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			it_s0 <= item;
		end
	end

	assign mag = MAG_W'(it_s0.sinp[SIN_W-1] ? -it_s0.sinp : it_s0.sinp);
	assign sq  = mag * mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r[0] <= 1'b0;
		end else if (ce) begin
			vld_r[0] <= vld_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			itm_r[0] <= it_s0;
			rem_r[0] <= ROOT_IN_W'((2*MAG_W)'(ONE_SQ) - sq);
			res_r[0] <= '0;
		end
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [ROOT_IN_W-1:0] BIT = ROOT_IN_W'(1) << (2 * (ROOT_STEPS - 1 - k));
		logic [ROOT_IN_W:0] trial;
		logic take;

		assign trial = {1'b0, res_r[k]} + {1'b0, BIT};
		assign take  = {1'b0, rem_r[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[k+1] <= 1'b0;
			end else if (ce) begin
				vld_r[k+1] <= vld_r[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				itm_r[k+1] <= itm_r[k];
				if (take) begin
					rem_r[k+1] <= ROOT_IN_W'({1'b0, rem_r[k]} - trial);
					res_r[k+1] <= (res_r[k] >> 1) + BIT;
				end else begin
					rem_r[k+1] <= rem_r[k];
					res_r[k+1] <= res_r[k] >> 1;
				end
			end
		end
	end

	assign px[0] = CORD_W'(itm_r[ROOT_STEPS].cosr);
	assign py[0] = CORD_W'(itm_r[ROOT_STEPS].sinr);
	assign px[1] = CORD_W'($signed({1'b0, res_r[ROOT_STEPS][MAG_W-1:0]}));
	assign py[1] = CORD_W'(itm_r[ROOT_STEPS].sinp);
	assign px[2] = CORD_W'(itm_r[ROOT_STEPS].cosy);
	assign py[2] = CORD_W'(itm_r[ROOT_STEPS].siny);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (ce) begin
			vld_c[0] <= vld_r[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			clamp_c[0] <= itm_r[ROOT_STEPS].clamp;
			neg_c[0]   <= itm_r[ROOT_STEPS].clamp_neg;
			for (int c = 0; c < 3; c++) begin
				ch_c[0][c].zero <= (px[c] == '0) && (py[c] == '0);
				if (px[c][CORD_W-1]) begin
					ch_c[0][c].x <= -px[c];
					ch_c[0][c].y <= -py[c];
					ch_c[0][c].z <= PI_ANG;
				end else begin
					ch_c[0][c].x <= px[c];
					ch_c[0][c].y <= py[c];
					ch_c[0][c].z <= '0;
				end
			end
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[j+1] <= 1'b0;
			end else if (ce) begin
				vld_c[j+1] <= vld_c[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				clamp_c[j+1] <= clamp_c[j];
				neg_c[j+1]   <= neg_c[j];
				for (int c = 0; c < 3; c++) begin
					ch_c[j+1][c].zero <= ch_c[j][c].zero;
					if (!ch_c[j][c].y[CORD_W-1]) begin
						ch_c[j+1][c].x <= ch_c[j][c].x + (ch_c[j][c].y >>> j);
						ch_c[j+1][c].y <= ch_c[j][c].y - (ch_c[j][c].x >>> j);
						ch_c[j+1][c].z <= ch_c[j][c].z + ATAN_TAB[j];
					end else begin
						ch_c[j+1][c].x <= ch_c[j][c].x - (ch_c[j][c].y >>> j);
						ch_c[j+1][c].y <= ch_c[j][c].y + (ch_c[j][c].x >>> j);
						ch_c[j+1][c].z <= ch_c[j][c].z - ATAN_TAB[j];
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rnd[c] = ch_c[STEPS][c].z + ROUND_HALF;
			ang[c] = ch_c[STEPS][c].zero ? '0 : $signed(rnd[c][ANG_W-1 -: OUT_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ce) begin
			out_valid_q <= vld_c[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			roll_q  <= ang[0];
			yaw_q   <= ang[2];
			clamp_q <= clamp_c[STEPS];
			if (clamp_c[STEPS]) begin
				pitch_q <= neg_c[STEPS] ? -HALF_PI : HALF_PI;
			end else begin
				pitch_q <= ang[1];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = clamp_q;

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clamp_q) |-> (pitch_q == HALF_PI || pitch_q == -HALF_PI))
		else $error("clamped pitch not at half pi");
endmodule
`default_nettype wire
